// ===== hdl/tlb_pkg.sv =====
// ----------------------------------------------------------------------------
// tlb_pkg: shared types and constants of the address translator
// Entry and cell control records, field widths, register indexes and the
// reset contents of the page table.
// ----------------------------------------------------------------------------
package tlb_pkg;

   localparam int ADDR_BITS           = 16;
   localparam int PAGE_BITS           = 4;
   localparam int FRAME_BITS          = 4;
   localparam int TABLE_WORD_BITS     = 32;
   localparam int CSR_INDEX_BITS      = 4;

   localparam int TLB_ENTRIES_DEFAULT = 4;
   localparam int OFFSET_BITS_DEFAULT = 12;

   localparam logic [TABLE_WORD_BITS-1:0] FRAME_LOW_RESET  = 32'h152F_E9C7;
   localparam logic [TABLE_WORD_BITS-1:0] FRAME_HIGH_RESET = 32'h86A4_DB30;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_TABLE_LOW  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_TABLE_HIGH = 4'd1;

   typedef struct packed {
      logic                  valid;
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
   } entry_type;

   // passed up the cell row: request taken, and a slot at or below is removed
   typedef struct packed {
      logic enable;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== hdl/tlb_cell.sv =====
// ----------------------------------------------------------------------------
// tlb_cell: one slot of the translation cache
// Holds a page/frame pair, compares it with the request page and, when it or
// a slot below is removed, takes the entry of its upper neighbour.
// ----------------------------------------------------------------------------
module tlb_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  tlb_pkg::entry_type             upper_entry,
   input  tlb_pkg::cell_ctrl_type         ctrl_in,
   input  logic                           remove,
   input  logic [tlb_pkg::PAGE_BITS-1:0]  lookup_page,
   output tlb_pkg::entry_type             entry,
   output logic                           match,
   output tlb_pkg::cell_ctrl_type         ctrl_out
);

   logic                            valid_ff, valid_in;
   logic [tlb_pkg::PAGE_BITS-1:0]   page_ff, page_in;
   logic [tlb_pkg::FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                            load;

   assign ctrl_out.enable = ctrl_in.enable;
   assign ctrl_out.shift  = ctrl_in.shift | remove;
   assign load            = ctrl_in.enable & ctrl_out.shift;

   assign match = valid_ff && (page_ff == lookup_page);

   assign entry.valid = valid_ff;
   assign entry.page  = page_ff;
   assign entry.frame = frame_ff;

   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      frame_in = frame_ff;
      if (load) begin
         valid_in = upper_entry.valid;
         page_in  = upper_entry.page;
         frame_in = upper_entry.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

endmodule

// ===== hdl/tlb_lru_address_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_lru_address_translator: fully associative TLB with LRU replacement
// Translates virtual addresses through a small cache in front of a
// 16-entry page table held in two configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one virtual address per request; rsp_ returns the physical
//   address in tdata and the hit flag in tuser. csr_ writes the page table:
//   index 0 holds entries 0 to 7, index 1 entries 8 to 15; other indexes are
//   ignored. csr_ready is always high; write only while no request is open.
//   The response is registered: a request taken in one cycle shows its
//   response in the next. One request per cycle is sustained while rsp_tready
//   is high: the tag compare, the pick of the slot to remove and the shift
//   along the cell row all settle in the same cycle.
//   The response register frees the input side: a new request is taken
//   whenever the held response leaves in the same cycle or none is held.
//   While rsp_tready stays low the response holds and req_tready drops.
//   Reset empties every slot, reloads the page table with its default and
//   drops rsp_tvalid. The most recently used slot is the top one.
// ----------------------------------------------------------------------------
module tlb_lru_address_translator #(
   parameter int TLB_ENTRIES = tlb_pkg::TLB_ENTRIES_DEFAULT,
   parameter int OFFSET_BITS = tlb_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tlb_pkg::ADDR_BITS-1:0]         req_tdata,   // virt_addr
   // response
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tlb_pkg::ADDR_BITS-1:0]         rsp_tdata,   // phys_addr
   output logic                                  rsp_tuser,   // tlb_hit
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tlb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tlb_pkg::TABLE_WORD_BITS-1:0]   csr_data
);

   localparam logic [31:0] OFFSET_MASK = (32'd1 << OFFSET_BITS) - 32'd1;

   logic [tlb_pkg::TABLE_WORD_BITS-1:0] table_low_ff, table_low_in;
   logic [tlb_pkg::TABLE_WORD_BITS-1:0] table_high_ff, table_high_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [tlb_pkg::ADDR_BITS-1:0]       rsp_data_ff, rsp_data_in;
   logic                                rsp_hit_ff, rsp_hit_in;

   logic                                req_accept;
   logic [31:0]                         virt_wide;
   logic [tlb_pkg::PAGE_BITS-1:0]       req_page;
   logic [31:0]                         offset_wide;
   logic [tlb_pkg::TABLE_WORD_BITS-1:0] table_word;
   logic [tlb_pkg::FRAME_BITS-1:0]      table_frame;
   logic [tlb_pkg::FRAME_BITS-1:0]      hit_frame;
   logic [tlb_pkg::FRAME_BITS-1:0]      frame;
   logic                                hit_any;
   logic                                free_any;
   logic [TLB_ENTRIES-1:0]              match_vec;
   logic [TLB_ENTRIES-1:0]              hit_sel;
   logic [TLB_ENTRIES-1:0]              free_sel;
   logic [TLB_ENTRIES-1:0]              remove_sel;
   logic [31:0]                         phys_wide;
   logic                                fill_done;

   tlb_pkg::entry_type     chain_entry [TLB_ENTRIES:0];
   tlb_pkg::cell_ctrl_type chain_ctrl  [TLB_ENTRIES:0];

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign virt_wide   = {{(32-tlb_pkg::ADDR_BITS){1'b0}}, req_tdata};
   assign req_page    = tlb_pkg::PAGE_BITS'(virt_wide >> OFFSET_BITS);
   assign offset_wide = virt_wide & OFFSET_MASK;

   // page table read on a miss
   assign table_word  = req_page[3] ? table_high_ff : table_low_ff;
   assign table_frame = table_word[{req_page[2:0], 2'b00} +: tlb_pkg::FRAME_BITS];

   // highest matching and highest empty slot
   always_comb begin
      hit_sel  = '0;
      free_sel = '0;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         if (match_vec[k]) begin
            hit_sel = '0;
            hit_sel[k] = 1'b1;
         end
         if (!chain_entry[k].valid) begin
            free_sel = '0;
            free_sel[k] = 1'b1;
         end
      end
   end

   assign hit_any  = |match_vec;
   assign free_any = |free_sel;

   always_comb begin
      hit_frame = '0;
      for (int k = 0; k < TLB_ENTRIES; k++) begin
         hit_frame = hit_frame | ({tlb_pkg::FRAME_BITS{hit_sel[k]}} & chain_entry[k].frame);
      end
   end

   always_comb begin
      if (hit_any) begin
         remove_sel = hit_sel;
      end else if (free_any) begin
         remove_sel = free_sel;
      end else begin
         remove_sel    = '0;
         remove_sel[0] = 1'b1;
      end
   end

   assign frame = hit_any ? hit_frame : table_frame;

   // new most recently used entry enters at the top of the row
   assign chain_entry[TLB_ENTRIES].valid = 1'b1;
   assign chain_entry[TLB_ENTRIES].page  = req_page;
   assign chain_entry[TLB_ENTRIES].frame = frame;

   assign chain_ctrl[0].enable = req_accept;
   assign chain_ctrl[0].shift  = 1'b0;

   for (genvar g = 0; g < TLB_ENTRIES; g++) begin : g_cell
      tlb_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .upper_entry (chain_entry[g+1]),
         .ctrl_in     (chain_ctrl[g]),
         .remove      (remove_sel[g]),
         .lookup_page (req_page),
         .entry       (chain_entry[g]),
         .match       (match_vec[g]),
         .ctrl_out    (chain_ctrl[g+1])
      );
   end

   // the top slot always loads when a request is taken
   assign fill_done = chain_ctrl[TLB_ENTRIES].enable & chain_ctrl[TLB_ENTRIES].shift;

   assign phys_wide = ({{(32-tlb_pkg::FRAME_BITS){1'b0}}, frame} << OFFSET_BITS) | offset_wide;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fill_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = phys_wide[tlb_pkg::ADDR_BITS-1:0];
         rsp_hit_in   = hit_any;
      end
   end

   always_comb begin
      table_low_in  = table_low_ff;
      table_high_in = table_high_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tlb_pkg::CSR_FRAME_TABLE_LOW:  table_low_in  = csr_data;
            tlb_pkg::CSR_FRAME_TABLE_HIGH: table_high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         table_low_ff  <= tlb_pkg::FRAME_LOW_RESET;
         table_high_ff <= tlb_pkg::FRAME_HIGH_RESET;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         table_low_ff  <= table_low_in;
         table_high_ff <= table_high_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

// ===== tb/sv/tb_tlb_lru_address_translator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tlb_lru_address_translator: self-checking bench for the LRU address TLB
// Streams virtual addresses into the translator under random source gaps and
// sink stalls. A local copy of the cache and page table predicts each
// physical address and hit flag, and every response is checked in order.
// ----------------------------------------------------------------------------
module tb_tlb_lru_address_translator;

   localparam int TLB_ENTRIES     = tlb_pkg::TLB_ENTRIES_DEFAULT;
   localparam int OFFSET_BITS     = tlb_pkg::OFFSET_BITS_DEFAULT;
   localparam int SETTLE_CYCLES   = 4;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_ITEMS     = 100;

   localparam logic [tlb_pkg::CSR_INDEX_BITS-1:0] CSR_INDEX_FIRST_UNUSED = 4'd2;
   localparam logic [tlb_pkg::CSR_INDEX_BITS-1:0] CSR_INDEX_MAX          = 4'hF;

   typedef struct packed {
      logic [tlb_pkg::ADDR_BITS-1:0] phys_addr;
      logic                          tlb_hit;
   } translation_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [tlb_pkg::ADDR_BITS-1:0]       req_tdata;   // virt_addr
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [tlb_pkg::ADDR_BITS-1:0]       rsp_tdata;   // phys_addr
   logic                                rsp_tuser;   // tlb_hit
   logic                                csr_valid;
   logic                                csr_ready;
   logic [tlb_pkg::CSR_INDEX_BITS-1:0]  csr_index;
   logic [tlb_pkg::TABLE_WORD_BITS-1:0] csr_data;

   // local copy of the page table and cache, slot TLB_ENTRIES-1 is newest
   logic [tlb_pkg::TABLE_WORD_BITS-1:0] table_low;
   logic [tlb_pkg::TABLE_WORD_BITS-1:0] table_high;
   tlb_pkg::entry_type                  tlb_slot [TLB_ENTRIES];

   translation_type pending_translations [$];
   int              mismatch_count;
   bit              gaps_on;
   bit              stalls_on;
   bit              hold_off_request;

   tlb_lru_address_translator #(
      .TLB_ENTRIES (TLB_ENTRIES),
      .OFFSET_BITS (OFFSET_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 24);
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, what);
   endfunction

   // walks the cache for one address and moves it to the newest slot
   function automatic translation_type predict_translation(
      logic [tlb_pkg::ADDR_BITS-1:0] va);
      translation_type                     outcome;
      logic [tlb_pkg::PAGE_BITS-1:0]       vpage;
      logic [tlb_pkg::FRAME_BITS-1:0]      vframe;
      logic [tlb_pkg::TABLE_WORD_BITS-1:0] word;
      int                                  hit_at;
      int                                  free_at;
      int                                  drop_at;
      vpage   = tlb_pkg::PAGE_BITS'(va >> OFFSET_BITS);
      hit_at  = -1;
      free_at = -1;
      for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
         if (hit_at < 0 && tlb_slot[k].valid && tlb_slot[k].page == vpage)
            hit_at = k;
      end
      if (hit_at >= 0) begin
         vframe  = tlb_slot[hit_at].frame;
         drop_at = hit_at;
      end else begin
         word   = vpage[tlb_pkg::PAGE_BITS-1] ? table_high : table_low;
         vframe = tlb_pkg::FRAME_BITS'(word >> (4 * int'(vpage[2:0])));
         for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
            if (free_at < 0 && !tlb_slot[k].valid)
               free_at = k;
         end
         drop_at = (free_at >= 0) ? free_at : 0;
      end
      for (int k = drop_at; k < TLB_ENTRIES - 1; k++)
         tlb_slot[k] = tlb_slot[k + 1];
      tlb_slot[TLB_ENTRIES - 1] = '{valid: 1'b1, page: vpage, frame: vframe};
      outcome.phys_addr = tlb_pkg::ADDR_BITS'((32'(vframe) << OFFSET_BITS)
                                     | (32'(va) & ((32'd1 << OFFSET_BITS) - 1)));
      outcome.tlb_hit   = (hit_at >= 0);
      return outcome;
   endfunction

   // called at a falling edge, returns at a falling edge with tvalid still high
   task automatic send_virt_addr(input logic [tlb_pkg::ADDR_BITS-1:0] va);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = va;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_translations.push_back(predict_translation(va));
      @(negedge clock);
   endtask

   task automatic write_frame_table(input logic [tlb_pkg::CSR_INDEX_BITS-1:0]  index,
                                    input logic [tlb_pkg::TABLE_WORD_BITS-1:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      if (index == tlb_pkg::CSR_FRAME_TABLE_LOW)
         table_low = value;
      else if (index == tlb_pkg::CSR_FRAME_TABLE_HIGH)
         table_high = value;
      @(negedge clock);
      csr_valid = 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_translations_done();
      req_tvalid = 1'b0;
      while (pending_translations.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // hand-picked walk: fills, hits in every slot position, evictions, extremes
   task automatic test_directed_lru();
      logic [tlb_pkg::ADDR_BITS-1:0] walk [20] = '{
         16'h0000, 16'hFFFF, 16'h0FFF, 16'hF000, 16'h1001, 16'h2800, 16'h3555,
         16'hF123, 16'h2456, 16'h2789, 16'h0ABC, 16'h1CDE, 16'h7FFF, 16'h8000,
         16'h7000, 16'h8FFF, 16'h5A5A, 16'hA5A5, 16'hC3C3, 16'h3C3C};
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      foreach (walk[i])
         send_virt_addr(walk[i]);
      wait_translations_done();
   endtask

   // cached pages keep their old frame after the table is rewritten
   task automatic test_stale_after_table_write();
      write_frame_table(tlb_pkg::CSR_FRAME_TABLE_LOW, ~tlb_pkg::FRAME_LOW_RESET);
      write_frame_table(tlb_pkg::CSR_FRAME_TABLE_HIGH, ~tlb_pkg::FRAME_HIGH_RESET);
      send_virt_addr(16'h5123);
      send_virt_addr(16'hA456);
      send_virt_addr(16'hC789);
      send_virt_addr(16'h3ABC);
      send_virt_addr(16'h6DEF);
      send_virt_addr(16'hD010);
      wait_translations_done();
   endtask

   task automatic test_random_traffic();
      logic [tlb_pkg::PAGE_BITS-1:0]      hot_pages [6];
      logic [tlb_pkg::PAGE_BITS-1:0]      vpage;
      logic [tlb_pkg::CSR_INDEX_BITS-1:0] spare_index;
      int                                 hot_count;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_translations_done();
         case (phase)
            0: begin
               write_frame_table(tlb_pkg::CSR_FRAME_TABLE_LOW, '0);
               write_frame_table(tlb_pkg::CSR_FRAME_TABLE_HIGH, '1);
            end
            1: begin
               write_frame_table(tlb_pkg::CSR_FRAME_TABLE_HIGH, '0);
               write_frame_table(tlb_pkg::CSR_FRAME_TABLE_LOW, '1);
            end
            default: begin
               write_frame_table(tlb_pkg::CSR_FRAME_TABLE_LOW, $urandom);
               write_frame_table(tlb_pkg::CSR_FRAME_TABLE_HIGH, $urandom);
            end
         endcase
         // writes to indexes past the table must leave it alone
         if (phase == 0 || $urandom_range(0, 1)) begin
            spare_index = (phase == 0) ? CSR_INDEX_MAX
                        : tlb_pkg::CSR_INDEX_BITS'($urandom_range(CSR_INDEX_FIRST_UNUSED,
                                                                  CSR_INDEX_MAX));
            write_frame_table(spare_index, $urandom);
         end
         gaps_on   = (phase % 3) != 0;
         stalls_on = (phase % 4) != 1;
         // small working set gives hits, more than four pages gives evictions
         hot_count = $urandom_range(1, 6);
         foreach (hot_pages[i])
            hot_pages[i] = tlb_pkg::PAGE_BITS'($urandom);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 85)
               vpage = hot_pages[$urandom_range(0, hot_count - 1)];
            else
               vpage = tlb_pkg::PAGE_BITS'($urandom);
            send_virt_addr({vpage, OFFSET_BITS'($urandom)});
         end
      end
      wait_translations_done();
   endtask

   // sink holds off while the source keeps offering, so the input stalls
   task automatic test_backpressure();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      @(posedge clock);
      hold_off_request = 1'b1;
      @(negedge clock);
      for (int n = 0; n < 40; n++)
         send_virt_addr(tlb_pkg::ADDR_BITS'($urandom));
      wait_translations_done();
   endtask

   initial begin : sink_side
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready       = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (stalls_on && stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = stalls_on ? pick_gap() : 0;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      translation_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_translations.size() == 0) begin
            note_mismatch($sformatf("response phys_addr %h hit %b with no request open",
                                    rsp_tdata, rsp_tuser));
         end else begin
            want = pending_translations.pop_front();
            if (rsp_tdata !== want.phys_addr)
               note_mismatch($sformatf("phys_addr expected %h actual %h",
                                       want.phys_addr, rsp_tdata));
            if (rsp_tuser !== want.tlb_hit)
               note_mismatch($sformatf("tlb_hit expected %b actual %b (phys_addr %h)",
                                       want.tlb_hit, rsp_tuser, want.phys_addr));
         end
      end
   end

   initial begin : run_tests
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      gaps_on          = 1'b0;
      stalls_on        = 1'b0;
      hold_off_request = 1'b0;
      mismatch_count   = 0;
      table_low        = tlb_pkg::FRAME_LOW_RESET;
      table_high       = tlb_pkg::FRAME_HIGH_RESET;
      foreach (tlb_slot[k])
         tlb_slot[k] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_lru();
      test_stale_after_table_write();
      test_random_traffic();
      test_backpressure();
      wait_translations_done();

      if (mismatch_count == 0 && pending_translations.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/tlb_pkg.sv
hdl/tlb_cell.sv
hdl/tlb_lru_address_translator.sv
tb/sv/tb_tlb_lru_address_translator.sv
